>>> sv/swtm_pkg.sv
`default_nettype none

package swtm_pkg;

   localparam int unsigned WINDOW_SIZE = 10;
   localparam int unsigned SAMPLE_W    = 32;
   localparam int unsigned SUM_W       = 34;
   localparam int unsigned CNT_W       = 4;

   localparam int unsigned MID_LOW     = 4;
   localparam int unsigned MID_CENTER  = 5;
   localparam int unsigned MID_HIGH    = 6;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = 2;
   localparam int unsigned QCNT_W      = 3;

   // divide by three, one hex digit per step
   localparam int unsigned DIVISOR     = 3;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned DIV_W       = 36;
   localparam int unsigned DIV_STEPS   = DIV_W / DIGIT_W;
   localparam int unsigned STEP_W      = 4;
   localparam int unsigned QUOT_W      = SAMPLE_W - DIGIT_W;
   localparam int unsigned PREM_W      = 2;
   localparam int unsigned PART_W      = PREM_W + DIGIT_W;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
   } entry_type;

   typedef struct packed {
      logic             valid;
      logic [SUM_W-1:0] sum;
   } sum_type;

   // partial remainder and next digit -> {quotient digit, new remainder}
   function automatic logic [PART_W-1:0] div3_digit(input logic [PART_W-1:0] value);
      logic [DIGIT_W-1:0] q;
      logic [PART_W-1:0]  r;
      q = '0;
      for (int k = 1; k < (1 << DIGIT_W); k++) begin
         if (value >= PART_W'(DIVISOR * k)) begin
            q = DIGIT_W'(k);
         end
      end
      r = value - ({2'b00, q} + {1'b0, q, 1'b0});
      return {q, r[PREM_W-1:0]};
   endfunction

endpackage

`default_nettype wire

>>> sv/sorted_window_trimmed_mean_unit.sv
// Flow: the transaction that completes a window of ten gives its result after it passes the
//   queue, sorted insertion, sum capture and 9 hex-digit divide-by-3 steps.
// Throughput: one sample per cycle while the queue is not full; the insertion row takes one
//   sample per cycle unless it holds a full window and the divider is still busy.
// Reset: synchronous, active high; clears counts, queue and valid flags. No clearing pass.
`default_nettype none

module sorted_window_trimmed_mean_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [swtm_pkg::SAMPLE_W-1:0]     req_tdata,   // [31:0] sample
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [swtm_pkg::SAMPLE_W-1:0]     rsp_tdata    // [31:0] trimmed_mean
);

   logic                queue_full;
   logic                push;
   swtm_pkg::entry_type push_entry;
   logic                pop;
   logic                head_valid;
   swtm_pkg::entry_type head_entry;
   logic                div_ready;
   swtm_pkg::sum_type   sum_bus;

   swtm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   swtm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .full       (queue_full)
   );

   swtm_sorter u_sorter (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .div_ready  (div_ready),
      .sum_out    (sum_bus)
   );

   swtm_div3 u_div3 (
      .clock      (clock),
      .reset      (reset),
      .sum_in     (sum_bus),
      .ready      (div_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

>>> sv/swtm_front.sv
`default_nettype none

module swtm_front (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [swtm_pkg::SAMPLE_W-1:0]       req_tdata,
   input  wire logic                                queue_full,
   output      logic                                push,
   output      swtm_pkg::entry_type                 push_entry
);

   logic [swtm_pkg::CNT_W-1:0] fill_ff;
   logic [swtm_pkg::CNT_W-1:0] fill_in;
   logic                       closes_window;

   assign req_tready    = !queue_full;
   assign push          = req_tvalid && req_tready;
   assign closes_window = (fill_ff == swtm_pkg::CNT_W'(swtm_pkg::WINDOW_SIZE - 1));

   assign push_entry.sample = req_tdata;
   assign push_entry.last   = closes_window;

   always_comb begin
      fill_in = fill_ff;
      if (push) begin
         fill_in = closes_window ? '0 : fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

`ifndef SYNTHESIS
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff < swtm_pkg::CNT_W'(swtm_pkg::WINDOW_SIZE))
      else $error("window fill count out of range");
`endif

endmodule

`default_nettype wire

>>> sv/swtm_queue.sv
`default_nettype none

module swtm_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire swtm_pkg::entry_type   push_entry,
   input  wire logic                  pop,
   output      logic                  head_valid,
   output      swtm_pkg::entry_type   head_entry,
   output      logic                  full
);

   swtm_pkg::entry_type slot_ff [swtm_pkg::QUEUE_DEPTH];

   logic [swtm_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [swtm_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [swtm_pkg::QCNT_W-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == swtm_pkg::QCNT_W'(swtm_pkg::QUEUE_DEPTH));
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

>>> sv/swtm_sorter.sv
`default_nettype none

module swtm_sorter (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire swtm_pkg::entry_type   head_entry,
   output      logic                  pop,
   input  wire logic                  div_ready,
   output      swtm_pkg::sum_type     sum_out
);

   // sorted insertion row; cells at or above the count act as +infinity
   logic [swtm_pkg::SAMPLE_W-1:0] cell_ff [swtm_pkg::WINDOW_SIZE];
   logic [swtm_pkg::SAMPLE_W-1:0] cell_in [swtm_pkg::WINDOW_SIZE];
   logic [swtm_pkg::WINDOW_SIZE-1:0] greater;

   logic [swtm_pkg::CNT_W-1:0] count_ff, count_in, base_count;
   logic                       full_ff, full_in;
   logic                       handoff;
   logic [swtm_pkg::SAMPLE_W-1:0] v;

   assign handoff    = full_ff && div_ready;
   assign pop        = head_valid && (!full_ff || div_ready);
   assign base_count = full_ff ? '0 : count_ff;
   assign v          = head_entry.sample;

   always_comb begin
      for (int i = 0; i < swtm_pkg::WINDOW_SIZE; i++) begin
         greater[i] = (swtm_pkg::CNT_W'(i) >= base_count) || (cell_ff[i] > v);
      end
      for (int i = 0; i < swtm_pkg::WINDOW_SIZE; i++) begin
         cell_in[i] = cell_ff[i];
         if (greater[i]) begin
            if (i > 0 && greater[(i > 0) ? i - 1 : 0]) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end else begin
               cell_in[i] = v;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      full_in  = full_ff;
      if (pop) begin
         count_in = base_count + 1'b1;
         full_in  = head_entry.last;
      end else if (handoff) begin
         count_in = '0;
         full_in  = 1'b0;
      end
   end

   assign sum_out.valid = handoff;
   assign sum_out.sum   = swtm_pkg::SUM_W'(cell_ff[swtm_pkg::MID_LOW])
                        + swtm_pkg::SUM_W'(cell_ff[swtm_pkg::MID_CENTER])
                        + swtm_pkg::SUM_W'(cell_ff[swtm_pkg::MID_HIGH]);

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < swtm_pkg::WINDOW_SIZE; i++) begin
            cell_ff[i] <= cell_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         full_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         full_ff  <= full_in;
      end
   end

`ifndef SYNTHESIS
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> count_ff == swtm_pkg::CNT_W'(swtm_pkg::WINDOW_SIZE))
      else $error("row marked full with wrong count");
   a_mid_sorted: assert property (@(posedge clock) disable iff (reset)
      full_ff |-> (cell_ff[swtm_pkg::MID_LOW] <= cell_ff[swtm_pkg::MID_CENTER])
               && (cell_ff[swtm_pkg::MID_CENTER] <= cell_ff[swtm_pkg::MID_HIGH]))
      else $error("middle cells not in order");
`endif

endmodule

`default_nettype wire

>>> sv/swtm_div3.sv
`default_nettype none

module swtm_div3 (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire swtm_pkg::sum_type               sum_in,
   output      logic                            ready,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [swtm_pkg::SAMPLE_W-1:0]   rsp_tdata
);

   logic [swtm_pkg::DIV_W-1:0]    dividend_ff, dividend_in;
   logic [swtm_pkg::PREM_W-1:0]   rem_ff, rem_in;
   logic [swtm_pkg::QUOT_W-1:0]   quot_ff, quot_in;
   logic [swtm_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          busy_ff, busy_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swtm_pkg::SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;

   logic [swtm_pkg::PART_W-1:0]   digit;
   logic [swtm_pkg::DIGIT_W-1:0]  qd;
   logic                          last_step, out_free, advance;

   assign ready      = !busy_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign digit = swtm_pkg::div3_digit({rem_ff,
                     dividend_ff[swtm_pkg::DIV_W-1 -: swtm_pkg::DIGIT_W]});
   assign qd        = digit[swtm_pkg::PART_W-1 -: swtm_pkg::DIGIT_W];
   assign last_step = (step_ff == swtm_pkg::STEP_W'(swtm_pkg::DIV_STEPS - 1));
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign advance   = busy_ff && (!last_step || out_free);

   always_comb begin
      dividend_in  = dividend_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      busy_in      = busy_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (sum_in.valid) begin
         dividend_in = swtm_pkg::DIV_W'(sum_in.sum);
         rem_in      = '0;
         step_in     = '0;
         busy_in     = 1'b1;
      end else if (advance) begin
         dividend_in = dividend_ff << swtm_pkg::DIGIT_W;
         rem_in      = digit[swtm_pkg::PREM_W-1:0];
         quot_in     = {quot_ff[swtm_pkg::QUOT_W-swtm_pkg::DIGIT_W-1:0], qd};
         step_in     = step_ff + 1'b1;
         if (last_step) begin
            busy_in      = 1'b0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = {quot_ff, qd};
         end
      end
   end

   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      sum_in.valid |-> !busy_ff)
      else $error("sum handed over while divider busy");
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> step_ff < swtm_pkg::STEP_W'(swtm_pkg::DIV_STEPS))
      else $error("divider step out of range");
`endif

endmodule

`default_nettype wire

>>> test/tb_sorted_window_trimmed_mean_unit.sv
`timescale 1ns / 1ps

module tb_sorted_window_trimmed_mean_unit;

   localparam int HOLD_CYCLES    = 250;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 40;
   localparam int RANDOM_WINDOWS = 50;
   localparam int TRAILING_ITEMS = 3;
   localparam int MAX_REPORTS    = 10;
   localparam int MAX_GAP        = 19;

   typedef logic [swtm_pkg::SAMPLE_W-1:0] sample_type;

   typedef struct {
      sample_type sample;
      bit         typed;    // mean below is known by inspection
      sample_type mean;
   } stim_row_type;

   typedef enum int {
      SPREAD_FULL,
      SPREAD_LOW,
      SPREAD_HIGH,
      SPREAD_EDGES
   } spread_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   sample_type req_tdata  = '0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   sample_type rsp_tdata;

   sample_type   pending_means[$];
   sample_type   window_buf[swtm_pkg::WINDOW_SIZE];
   int           window_fill    = 0;
   int           mismatches     = 0;
   int           stalled_cycles = 0;
   bit           hold_request   = 1'b0;
   stim_row_type directed_rows[25];

   sorted_window_trimmed_mean_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),    // [31:0] sample
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)     // [31:0] trimmed_mean
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // adds one sample to the shadow window; on the tenth, sorts and averages the middle three
   function automatic bit track_sample(input sample_type value, output sample_type mean);
      sample_type                 ordered[swtm_pkg::WINDOW_SIZE];
      sample_type                 held;
      int                         m;
      logic [swtm_pkg::SUM_W-1:0] mid_sum;
      mean = '0;
      window_buf[window_fill] = value;
      window_fill++;
      if (window_fill < swtm_pkg::WINDOW_SIZE) return 1'b0;
      window_fill = 0;
      ordered = window_buf;
      for (int k = 1; k < swtm_pkg::WINDOW_SIZE; k++) begin
         held = ordered[k];
         m = k;
         while (m > 0 && ordered[m-1] > held) begin
            ordered[m] = ordered[m-1];
            m--;
         end
         ordered[m] = held;
      end
      mid_sum = swtm_pkg::SUM_W'(ordered[swtm_pkg::MID_LOW])
              + swtm_pkg::SUM_W'(ordered[swtm_pkg::MID_CENTER])
              + swtm_pkg::SUM_W'(ordered[swtm_pkg::MID_HIGH]);
      mean = swtm_pkg::SAMPLE_W'(mid_sum / swtm_pkg::SUM_W'(swtm_pkg::DIVISOR));
      return 1'b1;
   endfunction

   function automatic sample_type draw_sample(input spread_type spread);
      case (spread)
         SPREAD_FULL: return sample_type'($urandom);
         SPREAD_LOW:  return sample_type'($urandom_range(0, 7));
         SPREAD_HIGH: return '1 - sample_type'($urandom_range(0, 7));
         default: begin
            case ($urandom_range(0, 2))
               0:       return '0;
               1:       return '1;
               default: return sample_type'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic send_sample(input sample_type value, input int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic log_accepted(input sample_type value, input bit typed,
                               input sample_type typed_mean);
      sample_type mean;
      if (track_sample(value, mean)) begin
         pending_means.push_back(typed ? typed_mean : mean);
      end
   endtask

   initial begin
      sample_type value;
      int         gap;
      bit         burst;
      spread_type spread;
      directed_rows = '{
         // all-zero window
         '{32'h0000_0000, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
         '{32'h0000_0000, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
         '{32'h0000_0000, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
         '{32'h0000_0000, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
         '{32'h0000_0000, 1'b0, 32'h0}, '{32'h0000_0000, 1'b1, 32'h0},
         // six max, four zero, interleaved: middle three are all max, 34-bit sum
         '{32'hFFFF_FFFF, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
         '{32'hFFFF_FFFF, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
         '{32'hFFFF_FFFF, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
         '{32'hFFFF_FFFF, 1'b0, 32'h0}, '{32'h0000_0000, 1'b0, 32'h0},
         '{32'hFFFF_FFFF, 1'b0, 32'h0}, '{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF},
         // start of a mixed window; random part completes it
         '{32'h0000_0001, 1'b0, 32'h0}, '{32'h8000_0000, 1'b0, 32'h0},
         '{32'h7FFF_FFFF, 1'b0, 32'h0}, '{32'h0000_0005, 1'b0, 32'h0},
         '{32'h0000_0005, 1'b0, 32'h0}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_sample(directed_rows[i].sample, $urandom_range(0, MAX_GAP));
         log_accepted(directed_rows[i].sample, directed_rows[i].typed, directed_rows[i].mean);
      end

      for (int w = 0; w < RANDOM_WINDOWS; w++) begin
         // receiver holds off mid-run while the sender streams back to back
         if (w == RANDOM_WINDOWS / 2) hold_request = 1'b1;
         burst = (w >= RANDOM_WINDOWS / 2 && w < RANDOM_WINDOWS / 2 + 6)
               || ($urandom_range(0, 3) == 0);
         spread = spread_type'($urandom_range(0, 3));
         for (int s = 0; s < swtm_pkg::WINDOW_SIZE; s++) begin
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
            value = draw_sample(spread);
            send_sample(value, gap);
            log_accepted(value, 1'b0, '0);
         end
      end

      // partial window at the end must not produce a result
      for (int s = 0; s < TRAILING_ITEMS; s++) begin
         value = draw_sample(SPREAD_FULL);
         send_sample(value, $urandom_range(0, MAX_GAP));
         log_accepted(value, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (pending_means.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      sample_type expected_mean;
      int         stall;
      int         taken;
      taken = 0;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            stall = HOLD_CYCLES;
         end else if (taken % 16 < 5) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
         if (pending_means.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected trimmed_mean transaction: got %h, no window pending",
                        rsp_tdata);
         end else begin
            expected_mean = pending_means.pop_front();
            if (rsp_tdata !== expected_mean) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("trimmed_mean mismatch: expected %h, got %h",
                           expected_mean, rsp_tdata);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

endmodule

>>> sorted_window_trimmed_mean_unit.f
sv/swtm_pkg.sv
sv/swtm_front.sv
sv/swtm_queue.sv
sv/swtm_sorter.sv
sv/swtm_div3.sv
sv/sorted_window_trimmed_mean_unit.sv
test/tb_sorted_window_trimmed_mean_unit.sv
